>>> design/mid_side_saturating_widener_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mid/side widener
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MID_SIDE_SATURATING_WIDENER_ASSERT_SVH
`define MID_SIDE_SATURATING_WIDENER_ASSERT_SVH

// condition holds at every edge
`define MSSW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent at the next edge
`define MSSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mssw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssw_pkg
// Shared types, codes and constants of the mid/side widener.
// ----------------------------------------------------------------------------
package mssw_pkg;

  localparam logic [2:0] REG_SIDE_DENSITY = 3'd0;
  localparam logic [2:0] REG_MID_DENSITY  = 3'd1;
  localparam logic [2:0] REG_WET_MIX      = 3'd2;
  localparam logic [2:0] REG_RATE_SCALE   = 3'd3;

  localparam logic [30:0] Q30_ONE          = 31'h4000_0000;
  localparam logic [29:0] TWO_OVER_PI_Q30  = 30'd683565276;
  localparam logic [21:0] DELAY_MAX        = 22'h3F_FFFF;
  localparam logic [2:0]  HORNER_LAST      = 3'd4;

  localparam logic signed [31:0] SC1  = 32'sd1686629713;
  localparam logic signed [31:0] SC3  = -32'sd693598668;
  localparam logic signed [31:0] SC5  = 32'sd85569306;
  localparam logic signed [31:0] SC7  = -32'sd5026996;
  localparam logic signed [31:0] SC9  = 32'sd172272;
  localparam logic signed [31:0] SC11 = -32'sd3864;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_LOAD, OP_DU_MUL, OP_DU_T,
    OP_S_SQ, OP_S_T2, OP_S_HMUL, OP_S_HACC, OP_S_FMUL, OP_S_FIN,
    OP_D_SQ1, OP_D_S2, OP_D_SQ2, OP_D_S4, OP_D_OMUL, OP_D_OFF,
    OP_SAT_SETUP, OP_SAT_M1, OP_SAT_R1, OP_SAT_M2, OP_SAT_R2,
    OP_H_WR, OP_H_NEAR, OP_H_M1, OP_H_M2, OP_H_FIN,
    OP_X_ML, OP_X_MW, OP_X_OL, OP_X_MRW, OP_X_OR
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DU_MUL, ST_DU_T,
    ST_S_SQ, ST_S_T2, ST_S_HMUL, ST_S_HACC, ST_S_FMUL, ST_S_FIN,
    ST_D_SQ1, ST_D_S2, ST_D_SQ2, ST_D_S4, ST_D_OMUL, ST_D_OFF,
    ST_SAT_SETUP, ST_SAT_M1, ST_SAT_R1, ST_SAT_M2, ST_SAT_R2,
    ST_H_WR, ST_H_NEAR, ST_H_M1, ST_H_M2, ST_H_FIN,
    ST_X_ML, ST_X_MW, ST_X_OL, ST_X_MRW, ST_X_OR
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] k;
    logic       side;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dly_nz;
    logic out_free;
  } status_t;

  // Horner coefficients, innermost first after SC11
  function automatic logic signed [31:0] sine_coef(input logic [2:0] k);
    logic signed [31:0] c;
    case (k)
      3'd0:    c = SC9;
      3'd1:    c = SC7;
      3'd2:    c = SC5;
      3'd3:    c = SC3;
      default: c = SC1;
    endcase
    return c;
  endfunction

endpackage

>>> design/mssw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mssw_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/mssw_ctrl.sv
`timescale 1ns / 1ps
`include "mid_side_saturating_widener_assert.svh"
// ----------------------------------------------------------------------------
// mssw_ctrl
// Sequencer: clear sweep, delay computation, per-frame saturate, delay and mix.
// ----------------------------------------------------------------------------
module mssw_ctrl import mssw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    cfg_we,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       path_r, path_nxt;
  logic       dctx_r, dctx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      k_r     <= '0;
      path_r  <= 1'b0;
      dctx_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      path_r  <= path_nxt;
      dctx_r  <= dctx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    path_nxt  = path_r;
    dctx_nxt  = dctx_r;
    cmd.op    = OP_NOP;
    cmd.k     = k_r;
    cmd.side  = path_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) state_nxt = ST_DU_MUL;
      end
      ST_IDLE: begin
        in_ready = !cfg_we;
        if (in_valid && !cfg_we) begin
          cmd.op    = OP_LOAD;
          path_nxt  = 1'b0;
          state_nxt = ST_SAT_SETUP;
        end
      end
      ST_DU_MUL: begin
        cmd.op    = OP_DU_MUL;
        dctx_nxt  = 1'b1;
        state_nxt = ST_DU_T;
      end
      ST_DU_T: begin
        cmd.op    = OP_DU_T;
        state_nxt = ST_S_SQ;
      end
      ST_S_SQ: begin
        cmd.op    = OP_S_SQ;
        state_nxt = ST_S_T2;
      end
      ST_S_T2: begin
        cmd.op    = OP_S_T2;
        k_nxt     = '0;
        state_nxt = ST_S_HMUL;
      end
      ST_S_HMUL: begin
        cmd.op    = OP_S_HMUL;
        state_nxt = ST_S_HACC;
      end
      ST_S_HACC: begin
        cmd.op = OP_S_HACC;
        if (k_r == HORNER_LAST) begin
          state_nxt = ST_S_FMUL;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = ST_S_HMUL;
        end
      end
      ST_S_FMUL: begin
        cmd.op    = OP_S_FMUL;
        state_nxt = ST_S_FIN;
      end
      ST_S_FIN: begin
        cmd.op    = OP_S_FIN;
        state_nxt = dctx_r ? ST_D_SQ1 : ST_SAT_M1;
      end
      ST_D_SQ1: begin
        cmd.op    = OP_D_SQ1;
        state_nxt = ST_D_S2;
      end
      ST_D_S2: begin
        cmd.op    = OP_D_S2;
        state_nxt = ST_D_SQ2;
      end
      ST_D_SQ2: begin
        cmd.op    = OP_D_SQ2;
        state_nxt = ST_D_S4;
      end
      ST_D_S4: begin
        cmd.op    = OP_D_S4;
        state_nxt = ST_D_OMUL;
      end
      ST_D_OMUL: begin
        cmd.op    = OP_D_OMUL;
        state_nxt = ST_D_OFF;
      end
      ST_D_OFF: begin
        cmd.op    = OP_D_OFF;
        state_nxt = ST_IDLE;
      end
      ST_SAT_SETUP: begin
        cmd.op    = OP_SAT_SETUP;
        dctx_nxt  = 1'b0;
        state_nxt = ST_S_SQ;
      end
      ST_SAT_M1: begin
        cmd.op    = OP_SAT_M1;
        state_nxt = ST_SAT_R1;
      end
      ST_SAT_R1: begin
        cmd.op    = OP_SAT_R1;
        state_nxt = ST_SAT_M2;
      end
      ST_SAT_M2: begin
        cmd.op    = OP_SAT_M2;
        state_nxt = ST_SAT_R2;
      end
      ST_SAT_R2: begin
        cmd.op = OP_SAT_R2;
        if (!path_r) begin
          path_nxt  = 1'b1;
          state_nxt = ST_SAT_SETUP;
        end else begin
          state_nxt = sts.dly_nz ? ST_H_WR : ST_X_ML;
        end
      end
      ST_H_WR: begin
        cmd.op    = OP_H_WR;
        state_nxt = ST_H_NEAR;
      end
      ST_H_NEAR: begin
        cmd.op    = OP_H_NEAR;
        state_nxt = ST_H_M1;
      end
      ST_H_M1: begin
        cmd.op    = OP_H_M1;
        state_nxt = ST_H_M2;
      end
      ST_H_M2: begin
        cmd.op    = OP_H_M2;
        state_nxt = ST_H_FIN;
      end
      ST_H_FIN: begin
        cmd.op    = OP_H_FIN;
        state_nxt = ST_X_ML;
      end
      ST_X_ML: begin
        cmd.op    = OP_X_ML;
        state_nxt = ST_X_MW;
      end
      ST_X_MW: begin
        cmd.op    = OP_X_MW;
        state_nxt = ST_X_OL;
      end
      ST_X_OL: begin
        cmd.op    = OP_X_OL;
        state_nxt = ST_X_MRW;
      end
      ST_X_MRW: begin
        cmd.op    = OP_X_MRW;
        state_nxt = ST_X_OR;
      end
      ST_X_OR: begin
        if (sts.out_free) begin
          cmd.op    = OP_X_OR;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we && state_r != ST_CLEAR) state_nxt = ST_DU_MUL;
  end

  `MSSW_ASSERT_NEXT(a_clear_to_delay, state_r == ST_CLEAR && sts.clr_last, state_r == ST_DU_MUL, "clear sweep did not start delay computation")
  `MSSW_ASSERT_NEXT(a_out_stall_hold, state_r == ST_X_OR && !sts.out_free && !cfg_we, state_r == ST_X_OR, "result dropped while output register busy")
  `MSSW_ASSERT(a_horner_bound, state_r != ST_S_HACC || k_r <= HORNER_LAST, "Horner step count out of range")

endmodule

>>> design/mssw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssw_dp
// Datapath: config registers, shared multiplier, side history RAM, output reg.
// ----------------------------------------------------------------------------
module mssw_dp import mssw_pkg::*; #(
  parameter int HISTORY_DEPTH = 2048,
  parameter int SAMPLE_BITS   = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output status_t                       sts,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [16:0]                   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out
);

  localparam int SB  = SAMPLE_BITS;
  localparam int S   = SB - 1;
  localparam int HW  = SB + 2;
  localparam int MW  = (SB + 3 > 34) ? SB + 3 : 34;
  localparam int PW  = 2 * MW;
  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int SHL = (S <= 30) ? 30 - S : 0;
  localparam int SHR = (S > 30) ? S - 30 : 0;
  localparam int CSH = 45 - S;
  localparam int TW  = SB + 31;

  localparam logic [SB:0]             ONE_S   = (SB + 1)'(1) << S;
  localparam logic signed [PW-1:0]    Q30_W   = PW'(Q30_ONE);
  localparam logic signed [PW-1:0]    OFF_MAX = PW'(DELAY_MAX);
  localparam logic signed [PW-1:0]    HI_W    = {{(PW - S){1'b0}}, {S{1'b1}}};
  localparam logic signed [PW-1:0]    LO_W    = {{(PW - S){1'b1}}, {S{1'b0}}};
  localparam logic [AW-1:0]           WP_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]             DEPTH_W = (AW + 1)'(HISTORY_DEPTH);

  // configuration
  logic signed [15:0] sd_r, md_r;
  logic [16:0]        wet_r;
  logic [14:0]        rate_r;

  // working registers
  logic signed [SB-1:0] l_r, r_r, ol_r;
  logic signed [SB:0]   v_r;
  logic [SB:0]          mag_r, res_r;
  logic [30:0]          t_r, t2_r, sn_r;
  logic signed [31:0]   acc_r;
  logic signed [PW-1:0] p_r, sum_r;
  logic signed [HW-1:0] mid_r, side_r, near_r, far_r;
  logic [5:0]           dw_r;
  logic [15:0]          df_r;
  logic [AW-1:0]        wp_r;
  logic                 out_valid_r;
  logic signed [SB-1:0] out_l_r, out_r_r;

  // combinational
  logic signed [15:0]   dens;
  logic                 dpos, dzero;
  logic [15:0]          amag;
  logic signed [SB:0]   v_cur;
  logic [SB:0]          v_mag;
  logic [SB-1:0]        tcl;
  logic [30:0]          tq, curve;
  logic signed [16:0]   dsub;
  logic [15:0]          u;
  logic [16:0]          w_eff, om;
  logic [18:0]          dry2;
  logic [19:0]          rate20;
  logic signed [HW:0]   msum, mdif;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod, fr, off_w;
  logic                 mul_en;
  logic [21:0]          off22;
  logic [30:0]          sn_cl;
  logic [SB:0]          c2;
  logic [HW-1:0]        resm;
  logic signed [HW-1:0] sat_val;
  logic [AW:0]          nd;
  logic [AW-1:0]        ni, fi, raddr, wp_next;
  logic                 ram_we;
  logic [HW-1:0]        ram_wdata, ram_rdata;
  logic                 out_load;

  function automatic logic signed [SB-1:0] clip_out(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] y;
    logic signed [SB-1:0] z;
    y = x >>> 18;
    if (y > HI_W) z = HI_W[SB-1:0];
    else if (y < LO_W) z = LO_W[SB-1:0];
    else z = y[SB-1:0];
    return z;
  endfunction

  always_comb begin
    dens   = cmd.side ? sd_r : md_r;
    dzero  = (dens == 16'sd0);
    dpos   = !dens[15] && !dzero;
    amag   = dens[15] ? 16'(-dens) : 16'(dens);
    om     = 17'd32768 - {1'b0, amag};
    v_cur  = cmd.side ? ((SB + 1)'(l_r) - (SB + 1)'(r_r))
                      : ((SB + 1)'(l_r) + (SB + 1)'(r_r));
    v_mag  = v_cur[SB] ? (SB + 1)'(-v_cur) : (SB + 1)'(v_cur);
    tcl    = (v_mag > ONE_S) ? ONE_S[SB-1:0] : v_mag[SB-1:0];
    tq     = (S <= 30) ? 31'({31'd0, tcl} << SHL) : 31'({31'd0, tcl} >> SHR);
    curve  = dpos ? sn_r : (Q30_ONE - sn_r);
    dsub   = 17'(sd_r) - 17'(md_r);
    u      = dsub[16] ? 16'(-dsub) : dsub[15:0];
    w_eff  = (wet_r > 17'd65536) ? 17'd65536 : wet_r;
    dry2   = (19'd131072 - 19'(w_eff)) << 1;
    rate20 = ({5'd0, rate_r} << 4) + ({5'd0, rate_r} << 2);
    msum   = (HW + 1)'(mid_r) + (HW + 1)'(side_r);
    mdif   = (HW + 1)'(mid_r) - (HW + 1)'(side_r);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_DU_MUL: begin mul_a = MW'(u);      mul_b = MW'(TWO_OVER_PI_Q30); end
      OP_S_SQ:   begin mul_a = MW'(t_r);    mul_b = MW'(t_r);             end
      OP_S_HMUL: begin mul_a = MW'(acc_r);  mul_b = MW'(t2_r);            end
      OP_S_FMUL: begin mul_a = MW'(acc_r);  mul_b = MW'(t_r);             end
      OP_D_SQ1:  begin mul_a = MW'(sn_r);   mul_b = MW'(sn_r);            end
      OP_D_SQ2:  begin mul_a = MW'(t2_r);   mul_b = MW'(t2_r);            end
      OP_D_OMUL: begin mul_a = MW'(t2_r);   mul_b = MW'(rate20);          end
      OP_SAT_M1: begin mul_a = MW'(mag_r);  mul_b = MW'(om);              end
      OP_SAT_M2: begin mul_a = MW'(curve);  mul_b = MW'(amag);            end
      OP_H_M1:   begin mul_a = MW'(near_r); mul_b = MW'(17'd65536 - {1'b0, df_r}); end
      OP_H_M2:   begin mul_a = MW'(far_r);  mul_b = MW'(df_r);            end
      OP_X_ML:   begin mul_a = MW'(l_r);    mul_b = MW'(dry2);            end
      OP_X_MW:   begin mul_a = MW'(msum);   mul_b = MW'(w_eff);           end
      OP_X_OL:   begin mul_a = MW'(r_r);    mul_b = MW'(dry2);            end
      OP_X_MRW:  begin mul_a = MW'(mdif);   mul_b = MW'(w_eff);           end
      default:   mul_en = 1'b0;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    fr      = p_r >>> 30;
    sn_cl   = (fr < 0) ? 31'd0 : ((fr > Q30_W) ? Q30_ONE : fr[30:0]);
    off_w   = p_r >>> 26;
    off22   = (off_w > OFF_MAX) ? DELAY_MAX : off_w[21:0];
    c2      = (SB + 1)'(p_r >>> CSH);
    resm    = {1'b0, res_r} + HW'(c2);
    sat_val = dzero ? HW'(v_r) : (v_r[SB] ? -$signed(resm) : $signed(resm));
    nd      = {1'b0, wp_r} - (AW + 1)'(dw_r);
    ni      = nd[AW] ? AW'(nd + DEPTH_W) : nd[AW-1:0];
    fi      = (ni == '0) ? WP_LAST : ni - AW'(1);
    raddr   = (cmd.op == OP_H_NEAR) ? fi : ni;
    wp_next = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
    ram_we  = (cmd.op == OP_CLR) || (cmd.op == OP_H_WR);
    ram_wdata = (cmd.op == OP_CLR) ? '0 : side_r;
    out_load  = (cmd.op == OP_X_OR);
  end

  mssw_ram #(
    .WIDTH (HW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r        <= '0;
      md_r        <= '0;
      wet_r       <= 17'd65536;
      rate_r      <= 15'd4096;
      dw_r        <= '0;
      df_r        <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIDE_DENSITY: sd_r   <= cfg_data[15:0];
          REG_MID_DENSITY:  md_r   <= cfg_data[15:0];
          REG_WET_MIX:      wet_r  <= cfg_data;
          REG_RATE_SCALE:   rate_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_D_OFF) begin
        dw_r <= off22[21:16];
        df_r <= off22[15:0];
      end
      if (cmd.op == OP_CLR || cmd.op == OP_X_OR) wp_r <= wp_next;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (mul_en) p_r <= prod;
    unique case (cmd.op)
      OP_LOAD: begin
        l_r <= in_left_in;
        r_r <= in_right_in;
      end
      OP_DU_T:   t_r <= 31'(p_r >>> 16);
      OP_S_T2: begin
        t2_r  <= 31'(p_r >>> 30);
        acc_r <= SC11;
      end
      OP_S_HACC: acc_r <= sine_coef(cmd.k) + 32'(p_r >>> 30);
      OP_S_FIN:  sn_r <= sn_cl;
      OP_D_S2:   t2_r <= 31'(p_r >>> 30);
      OP_D_S4:   t2_r <= 31'(p_r >>> 30);
      OP_SAT_SETUP: begin
        v_r   <= v_cur;
        mag_r <= v_mag;
        t_r   <= dpos ? tq : (Q30_ONE - tq);
      end
      OP_SAT_R1: res_r <= (SB + 1)'(p_r >>> 15);
      OP_SAT_R2: begin
        if (cmd.side) side_r <= sat_val;
        else mid_r <= sat_val;
      end
      OP_H_NEAR: near_r <= (dw_r == '0) ? side_r : $signed(ram_rdata);
      OP_H_M1:   far_r <= $signed(ram_rdata);
      OP_H_M2:   sum_r <= p_r;
      OP_H_FIN:  side_r <= HW'((sum_r + p_r) >>> 16);
      OP_X_MW:   sum_r <= p_r;
      OP_X_OL:   ol_r <= clip_out(sum_r + p_r);
      OP_X_MRW:  sum_r <= p_r;
      OP_X_OR: begin
        out_l_r <= ol_r;
        out_r_r <= clip_out(sum_r + p_r);
      end
      default: ;
    endcase
  end

  assign sts.clr_last = (wp_r == WP_LAST);
  assign sts.dly_nz   = (dw_r != '0) || (df_r != '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;

endmodule

>>> design/mid_side_saturating_widener.sv
`timescale 1ns / 1ps
// Frames are processed one at a time on the single shared multiplier, which runs both
// sine saturators in turn; a new frame is accepted only in the idle state.
// The result and out_valid are registered together in the output register.
// Reset: synchronous, active low; then a clearing pass over the side history RAM
// and a delay computation before the first frame.
// Each register write restarts the delay computation.
// ----------------------------------------------------------------------------
// mid_side_saturating_widener
// Mid/side saturating stereo widener with fractional side delay.
// ----------------------------------------------------------------------------
module mid_side_saturating_widener import mssw_pkg::*; #(
  parameter int HISTORY_DEPTH = 2048,
  parameter int SAMPLE_BITS   = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [16:0]                   cfg_data
);

  cmd_t    cmd;
  status_t sts;

  mssw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_we   (cfg_we),
    .sts      (sts),
    .cmd      (cmd)
  );

  mssw_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

endmodule

>>> tb/mssw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssw_checker
// Watches the frame, result and register ports of the mid/side widener.
// Keeps its own copy of the registers, side history and delay, predicts
// each output frame, and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module mssw_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [23:0] in_left_in,
  input  logic signed [23:0] in_right_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] out_left_out,
  input  logic signed [23:0] out_right_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 mismatches,
  output int                 pending
);
  import mssw_pkg::*;

  localparam int     DEPTH    = 2048;
  localparam longint UNIT     = 64'sd1 << 30;
  localparam longint TWO_PI_R = 64'sd683565276;
  localparam longint DLY_TOP  = (64'sd64 << 16) - 1;
  localparam longint S_HI     = 64'sd8388607;
  localparam longint S_LO     = -64'sd8388608;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } frame_t;

  logic [15:0] side_dens;
  logic [15:0] mid_dens;
  logic [16:0] wet;
  logic [14:0] rate;
  longint      side_hist [DEPTH];
  int          wr_pos;
  longint      delay_q16;
  frame_t      expected_frames [$];

  function automatic longint sine_q30(longint t_in);
    longint t, t2, acc, r;
    t = t_in;
    if (t < 0) t = 0;
    if (t > UNIT) t = UNIT;
    t2  = (t * t) >>> 30;
    acc = longint'(SC11);
    acc = longint'(SC9) + ((acc * t2) >>> 30);
    acc = longint'(SC7) + ((acc * t2) >>> 30);
    acc = longint'(SC5) + ((acc * t2) >>> 30);
    acc = longint'(SC3) + ((acc * t2) >>> 30);
    acc = longint'(SC1) + ((acc * t2) >>> 30);
    r   = (acc * t) >>> 30;
    if (r < 0) r = 0;
    if (r > UNIT) r = UNIT;
    return r;
  endfunction

  function automatic longint shape_path(longint v, longint dens);
    longint mag, amag, t, curve, res;
    if (dens == 0) return v;
    mag  = (v < 0) ? -v : v;
    amag = (dens < 0) ? -dens : dens;
    t    = (mag > (64'sd1 << 23)) ? (64'sd1 << 23) : mag;
    t    = t << 7;
    curve = (dens > 0) ? sine_q30(t) : UNIT - sine_q30(UNIT - t);
    res  = ((mag * (32768 - amag)) >>> 15) + ((curve * amag) >>> 22);
    return (v < 0) ? -res : res;
  endfunction

  function automatic longint side_delay(logic [15:0] sd, logic [15:0] md, logic [14:0] rt);
    longint u, t, sn, s2, s4, off;
    u = longint'($signed(sd)) - longint'($signed(md));
    if (u < 0) u = -u;
    t   = (u * TWO_PI_R) >>> 16;
    sn  = sine_q30(t);
    s2  = (sn * sn) >>> 30;
    s4  = (s2 * s2) >>> 30;
    off = (s4 * 20 * longint'(rt)) >>> 26;
    if (off > DLY_TOP) off = DLY_TOP;
    return off;
  endfunction

  function automatic longint clip24(longint x);
    if (x > S_HI) return S_HI;
    if (x < S_LO) return S_LO;
    return x;
  endfunction

  function automatic frame_t widen_frame(logic signed [23:0] li, logic signed [23:0] ri);
    longint l, r, mid, side, w, f, ol, orr;
    int     whole, ni, fi, pos;
    frame_t res;
    l    = longint'(li);
    r    = longint'(ri);
    mid  = shape_path(l + r, longint'($signed(mid_dens)));
    side = shape_path(l - r, longint'($signed(side_dens)));
    w    = (wet > 17'd65536) ? 65536 : longint'(wet);
    pos  = wr_pos;
    if (delay_q16 != 0) begin
      whole = int'(delay_q16 >>> 16);
      f     = delay_q16 & 64'hFFFF;
      ni    = (pos + DEPTH - whole) % DEPTH;
      fi    = (ni + DEPTH - 1) % DEPTH;
      side_hist[pos] = side;
      side  = (side_hist[ni] * (65536 - f) + side_hist[fi] * f) >>> 16;
    end
    wr_pos = (pos + 1) % DEPTH;
    ol  = clip24((l * 2 * (131072 - w) + (mid + side) * w) >>> 18);
    orr = clip24((r * 2 * (131072 - w) + (mid - side) * w) >>> 18);
    res.left  = ol[23:0];
    res.right = orr[23:0];
    return res;
  endfunction

  always @(posedge clk) begin
    frame_t exp_f;
    if (!rst_n) begin
      side_dens = '0;
      mid_dens  = '0;
      wet       = 17'd65536;
      rate      = 15'd4096;
      for (int i = 0; i < DEPTH; i++) side_hist[i] = 0;
      wr_pos    = 0;
      delay_q16 = side_delay(side_dens, mid_dens, rate);
      expected_frames.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SIDE_DENSITY: side_dens = cfg_data[15:0];
          REG_MID_DENSITY:  mid_dens  = cfg_data[15:0];
          REG_WET_MIX:      wet       = cfg_data;
          REG_RATE_SCALE:   rate      = cfg_data[14:0];
          default: ;
        endcase
        delay_q16 = side_delay(side_dens, mid_dens, rate);
      end
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected output frame: left %0d right %0d",
                     out_left_out, out_right_out);
          mismatches++;
        end else begin
          exp_f = expected_frames.pop_front();
          if (exp_f.left !== out_left_out || exp_f.right !== out_right_out) begin
            if (mismatches < 10)
              $display("frame mismatch: expected left %0d right %0d, got left %0d right %0d",
                       exp_f.left, exp_f.right, out_left_out, out_right_out);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_frames.push_back(widen_frame(in_left_in, in_right_in));
    end
    pending = expected_frames.size();
  end

endmodule

>>> tb/tb_mid_side_saturating_widener.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mid_side_saturating_widener
// Drives stereo frames and register settings into the widener under several
// idle and stall patterns, including a long output hold-off; the checker
// beside the block predicts and compares every output frame.
// ----------------------------------------------------------------------------
module tb_mid_side_saturating_widener;
  import mssw_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [23:0] in_left_in = '0;
  logic signed [23:0] in_right_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] out_left_out;
  logic signed [23:0] out_right_out;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [16:0]        cfg_data = '0;
  int                 mismatches;
  int                 pending;

  int idle_pct  = 0;
  int stall_pct = 0;
  bit long_hold = 1'b0;

  always #2 clk = ~clk;

  mid_side_saturating_widener u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_left_in(in_left_in), .in_right_in(in_right_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mssw_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_left_in(in_left_in), .in_right_in(in_right_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  // receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(2047)) - 1024);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_left_in  <= l;
    in_right_in <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (30) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] sd, input logic [15:0] md,
                               input logic [16:0] wm, input logic [14:0] rs);
    write_reg(REG_SIDE_DENSITY, {1'b0, sd});
    write_reg(REG_MID_DENSITY, {1'b0, md});
    write_reg(REG_WET_MIX, wm);
    write_reg(REG_RATE_SCALE, {2'b0, rs});
  endtask

  initial begin
    logic [15:0] sd_tab [8];
    logic [15:0] md_tab [8];
    logic [16:0] wm_tab [8];
    logic [14:0] rs_tab [8];
    sd_tab = '{16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h4000, 16'h0000, 16'h0000, 16'h0000};
    md_tab = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000};
    wm_tab = '{17'd65536, 17'd0, 17'h1FFFF, 17'd32768, 17'd65536, 17'd0, 17'd0, 17'd0};
    rs_tab = '{15'd32767, 15'd1024, 15'd0, 15'd4096, 15'd8192, 15'd0, 15'd0, 15'd0};
    for (int k = 5; k < 8; k++) begin
      sd_tab[k] = 16'($urandom);
      md_tab[k] = 16'($urandom);
      wm_tab[k] = 17'($urandom_range(65536));
      rs_tab[k] = 15'($urandom_range(32767, 1024));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero density, no delay
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h7FFFFF, 24'h7FFFFF);
    send_frame(24'h800000, 24'h800000);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h000001, 24'hFFFFFF);
    drain();
    write_reg(3'd5, 17'h1FFFF);
    write_reg(3'd7, 17'h00001);
    // long delay, saturating densities
    apply_setting(16'h7FFF, 16'h8000, 17'h1FFFF, 15'd32767);
    for (int i = 0; i < 80; i++) send_frame(rand_sample(), rand_sample());
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h7FFFFF, 24'h7FFFFF);
    send_frame(24'h800000, 24'h800000);
    drain();

    for (int p = 0; p < 8; p++) begin
      apply_setting(sd_tab[p], md_tab[p], wm_tab[p], rs_tab[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      if (p == 3) begin
        idle_pct = 0;
        long_hold = 1'b1;
      end
      for (int i = 0; i < 56; i++) begin
        send_frame(rand_sample(), rand_sample());
        if (i == 28) drain();
      end
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/mssw_pkg.sv
design/mssw_ram.sv
design/mssw_ctrl.sv
design/mssw_dp.sv
design/mid_side_saturating_widener.sv
tb/mssw_checker.sv
tb/tb_mid_side_saturating_widener.sv
